@@ rtl/plef_pkg.sv @@
`timescale 1ns / 1ps

package plef_pkg;

    localparam int LIMIT_W = 16;
    localparam int THRESH_W = 20;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam int CMD_W = 3;
    localparam int LABEL_W = 16;
    localparam int DIST_W = 20;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [LABEL_W-1:0] OWNER_LABEL = 16'sd1;

    localparam logic [CFG_INDEX_W-1:0] CFG_DET_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RECOG_LIMIT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PREVENT = 3'd4;

    localparam logic [LIMIT_W-1:0] DET_LIMIT_RESET = 16'd10;
    localparam logic [LIMIT_W-1:0] RECOG_LIMIT_RESET = 16'd10;
    localparam logic [LIMIT_W-1:0] INTERVAL_RESET = 16'd60;
    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 20'd20480;

    typedef enum logic [1:0] {
        MODE_SECURE = 2'd0,
        MODE_ALERT = 2'd1,
        MODE_LOCKDOWN = 2'd2
    } mode_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 3'd0,
        CMD_DET_FAIL = 3'd1,
        CMD_DET_OK = 3'd2,
        CMD_RECOG_CHECK = 3'd3,
        CMD_RECOG_FAIL = 3'd4,
        CMD_RECOG_OK = 3'd5,
        CMD_FORCE_LOCK = 3'd6
    } cmd_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] det_limit;
        logic [LIMIT_W-1:0] recog_limit;
        logic [LIMIT_W-1:0] interval;
        logic [THRESH_W-1:0] threshold;
        logic prevent;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic match;
    } item_t;

endpackage

@@ rtl/plef_if.sv @@
`timescale 1ns / 1ps

interface plef_in_if;
    import plef_pkg::*;

    logic valid;
    logic ready;
    logic [CMD_W-1:0] command;
    logic signed [LABEL_W-1:0] face_label;
    logic [DIST_W-1:0] match_distance;

    modport source (output valid, command, face_label, match_distance, input ready);
    modport sink (input valid, command, face_label, match_distance, output ready);
endinterface

interface plef_out_if;
    logic valid;
    logic ready;
    logic [1:0] mode;
    logic need_recognition;
    logic mode_changed;
    logic lock_pulse;
    logic lock_suppressed;
    logic unlock_pulse;
    logic is_match;

    modport source (output valid, mode, need_recognition, mode_changed, lock_pulse,
        lock_suppressed, unlock_pulse, is_match, input ready);
    modport sink (input valid, mode, need_recognition, mode_changed, lock_pulse,
        lock_suppressed, unlock_pulse, is_match, output ready);
endinterface

@@ rtl/plef_front.sv @@
`timescale 1ns / 1ps

module plef_front
    import plef_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic [THRESH_W-1:0] threshold,
    plef_in_if.sink in_ch,
    output logic push_valid,
    output item_t push_item,
    input  logic push_ready
);

    logic stage_valid_reg;
    logic stage_valid_next;
    item_t stage_item_reg;
    item_t stage_item_next;
    logic take;

    assign in_ch.ready = !stage_valid_reg || push_ready;
    assign take = in_ch.valid && in_ch.ready;

    // The recognition check is settled here, so the back end sees one flag.
    always_comb
    begin
        stage_item_next.op = in_ch.command;
        stage_item_next.match = (in_ch.command == CMD_RECOG_CHECK)
            && (in_ch.face_label == OWNER_LABEL)
            && (in_ch.match_distance <= threshold);
        stage_valid_next = take || (stage_valid_reg && !push_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_item_reg <= stage_item_next;
        end
    end

    assign push_valid = stage_valid_reg;
    assign push_item = stage_item_reg;

endmodule

@@ rtl/plef_queue.sv @@
`timescale 1ns / 1ps

module plef_queue
    import plef_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  item_t push_item,
    output logic push_ready,
    output logic pop_valid,
    output item_t pop_item,
    input  logic pop_ready
);

    item_t entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic push;
    logic pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign push = push_valid && push_ready;
    assign pop = pop_valid && pop_ready;
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/plef_back.sv @@
`timescale 1ns / 1ps

module plef_back
    import plef_pkg::*;
#(
    parameter int FAIL_COUNT_BITS = 16,
    parameter int GAP_BITS = 17
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic pop_valid,
    input  item_t pop_item,
    output logic pop_ready,
    plef_out_if.source out_ch
);

    localparam int FCMP_W = (FAIL_COUNT_BITS > LIMIT_W) ? FAIL_COUNT_BITS : LIMIT_W;
    localparam int GCMP_W = (GAP_BITS > LIMIT_W) ? GAP_BITS : LIMIT_W;

    mode_t mode_reg;
    mode_t mode_next;
    logic [FAIL_COUNT_BITS-1:0] det_cnt_reg;
    logic [FAIL_COUNT_BITS-1:0] det_cnt_next;
    logic [FAIL_COUNT_BITS-1:0] det_cnt_inc;
    logic [FAIL_COUNT_BITS-1:0] recog_cnt_reg;
    logic [FAIL_COUNT_BITS-1:0] recog_cnt_next;
    logic [FAIL_COUNT_BITS-1:0] recog_cnt_inc;
    logic [GAP_BITS-1:0] gap_reg;
    logic [GAP_BITS-1:0] gap_next;
    logic lock_event;
    logic fire;
    cmd_t op;

    logic out_valid_reg;
    logic out_valid_next;
    mode_t out_mode_reg;
    logic out_changed_reg;
    logic out_lock_reg;
    logic out_lock_next;
    logic out_supp_reg;
    logic out_supp_next;
    logic out_unlock_reg;
    logic out_unlock_next;
    logic out_match_reg;

    assign op = cmd_t'(pop_item.op);
    assign pop_ready = !out_valid_reg || out_ch.ready;
    assign fire = pop_valid && pop_ready;
    assign det_cnt_inc = (det_cnt_reg == '1) ? det_cnt_reg : det_cnt_reg + 1'b1;
    assign recog_cnt_inc = (recog_cnt_reg == '1) ? recog_cnt_reg : recog_cnt_reg + 1'b1;

    // Next state of the mode machine and its counters.
    always_comb
    begin
        mode_next = mode_reg;
        det_cnt_next = det_cnt_reg;
        recog_cnt_next = recog_cnt_reg;
        gap_next = gap_reg;
        lock_event = 1'b0;
        if (fire)
        begin
            unique case (op)
                CMD_TICK:
                begin
                    gap_next = (gap_reg == '1) ? gap_reg : gap_reg + 1'b1;
                end
                CMD_DET_FAIL:
                begin
                    det_cnt_next = det_cnt_inc;
                    if (FCMP_W'(det_cnt_inc) > FCMP_W'(cfg.det_limit))
                    begin
                        mode_next = MODE_ALERT;
                    end
                end
                CMD_DET_OK:
                begin
                    det_cnt_next = '0;
                    if (GCMP_W'(gap_reg) > GCMP_W'(cfg.interval))
                    begin
                        mode_next = MODE_ALERT;
                    end
                end
                CMD_RECOG_FAIL:
                begin
                    recog_cnt_next = recog_cnt_inc;
                    if ((FCMP_W'(recog_cnt_inc) > FCMP_W'(cfg.recog_limit))
                        && (mode_reg != MODE_LOCKDOWN))
                    begin
                        mode_next = MODE_LOCKDOWN;
                        lock_event = 1'b1;
                    end
                end
                CMD_RECOG_OK:
                begin
                    recog_cnt_next = '0;
                    gap_next = '0;
                    mode_next = MODE_SECURE;
                end
                CMD_FORCE_LOCK:
                begin
                    mode_next = MODE_LOCKDOWN;
                    lock_event = 1'b1;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    // Result word for the item being carried out.
    always_comb
    begin
        out_valid_next = fire || (out_valid_reg && !out_ch.ready);
        out_lock_next = lock_event && !cfg.prevent;
        out_supp_next = lock_event && cfg.prevent;
        out_unlock_next = (op == CMD_RECOG_OK) && (mode_reg == MODE_LOCKDOWN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SECURE;
            det_cnt_reg <= '0;
            recog_cnt_reg <= '0;
            gap_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            det_cnt_reg <= det_cnt_next;
            recog_cnt_reg <= recog_cnt_next;
            gap_reg <= gap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_mode_reg <= mode_next;
            out_changed_reg <= (mode_next != mode_reg);
            out_lock_reg <= out_lock_next;
            out_supp_reg <= out_supp_next;
            out_unlock_reg <= out_unlock_next;
            out_match_reg <= pop_item.match;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.mode = out_mode_reg;
    assign out_ch.need_recognition = (out_mode_reg != MODE_SECURE);
    assign out_ch.mode_changed = out_changed_reg;
    assign out_ch.lock_pulse = out_lock_reg;
    assign out_ch.lock_suppressed = out_supp_reg;
    assign out_ch.unlock_pulse = out_unlock_reg;
    assign out_ch.is_match = out_match_reg;

endmodule

@@ rtl/presence_lock_escalation_fsm_unit.sv @@
`timescale 1ns / 1ps
// Channel   Role     Word
// in_ch     sink     command, face_label, match_distance
// out_ch    source   mode, need_recognition, mode_changed, lock_pulse,
//                    lock_suppressed, unlock_pulse, is_match
// cfg_*     write    cfg_we, cfg_index, cfg_wdata
//
// One word is taken and one result given per cycle when neither side stalls.
// A word accepted on in_ch is offered on out_ch after passing the front
// register, the two-entry queue and the output register of the mode machine.
// Reset clears the mode to secure, the counters and every valid flag at once.
// A stalled out_ch fills the queue first; in_ch drops ready once the queue and the
// front register are both full.

module presence_lock_escalation_fsm_unit
    import plef_pkg::*;
#(
    parameter int FAIL_COUNT_BITS = 16,
    parameter int GAP_BITS = 17
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    plef_in_if.sink in_ch,
    plef_out_if.source out_ch
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic push_valid;
    logic push_ready;
    item_t push_item;
    logic pop_valid;
    logic pop_ready;
    item_t pop_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DET_LIMIT: cfg_next.det_limit = cfg_wdata[LIMIT_W-1:0];
                CFG_RECOG_LIMIT: cfg_next.recog_limit = cfg_wdata[LIMIT_W-1:0];
                CFG_INTERVAL: cfg_next.interval = cfg_wdata[LIMIT_W-1:0];
                CFG_THRESHOLD: cfg_next.threshold = cfg_wdata[THRESH_W-1:0];
                CFG_PREVENT: cfg_next.prevent = cfg_wdata[0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.det_limit <= DET_LIMIT_RESET;
            cfg_reg.recog_limit <= RECOG_LIMIT_RESET;
            cfg_reg.interval <= INTERVAL_RESET;
            cfg_reg.threshold <= THRESHOLD_RESET;
            cfg_reg.prevent <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    plef_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .threshold  (cfg_reg.threshold),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    plef_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    plef_back #(
        .FAIL_COUNT_BITS (FAIL_COUNT_BITS),
        .GAP_BITS        (GAP_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop_ready (pop_ready),
        .out_ch    (out_ch)
    );

endmodule

@@ rtl/plef_checker.sv @@
`timescale 1ns / 1ps

module plef_checker
    import plef_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic [1:0] out_mode,
    input logic out_mode_changed,
    input logic out_lock_pulse,
    input logic out_lock_suppressed,
    input logic out_unlock_pulse
);

    // A result that waits keeps its word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_mode)
            && $stable(out_lock_pulse))
    else $error("stalled result changed");

    // A lock command, issued or held back, always leaves the block in lockdown.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_lock_pulse || out_lock_suppressed)
            |-> out_mode == MODE_LOCKDOWN && !(out_lock_pulse && out_lock_suppressed))
    else $error("lock flags inconsistent with mode");

    // Unlock only comes with a change back to secure.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_unlock_pulse |-> out_mode == MODE_SECURE && out_mode_changed)
    else $error("unlock without return to secure");

    // Nothing is offered straight out of reset.
    assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
    else $error("result offered during reset");

endmodule

bind presence_lock_escalation_fsm_unit plef_checker u_plef_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_mode            (out_ch.mode),
    .out_mode_changed    (out_ch.mode_changed),
    .out_lock_pulse      (out_ch.lock_pulse),
    .out_lock_suppressed (out_ch.lock_suppressed),
    .out_unlock_pulse    (out_ch.unlock_pulse)
);

@@ verif/plef_escalation_monitor.sv @@
`timescale 1ns / 1ps

module plef_escalation_monitor
    import plef_pkg::*;
#(
    parameter int FAIL_COUNT_BITS = 16,
    parameter int GAP_BITS = 17
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    plef_in_if in_ch,
    plef_out_if out_ch,
    output int pending,
    output int fail_count
);

    typedef struct packed {
        mode_t mode;
        logic need_recognition;
        logic mode_changed;
        logic lock_pulse;
        logic lock_suppressed;
        logic unlock_pulse;
        logic is_match;
    } verdict_t;

    localparam logic [FAIL_COUNT_BITS-1:0] FAIL_MAX = '1;
    localparam logic [GAP_BITS-1:0] GAP_MAX = '1;

    cfg_t settings;
    mode_t mode_now;
    logic [FAIL_COUNT_BITS-1:0] det_fails;
    logic [FAIL_COUNT_BITS-1:0] recog_fails;
    logic [GAP_BITS-1:0] gap_seconds;
    verdict_t expected_verdicts[$];
    int errors;
    int results_seen;

    function automatic verdict_t escalate(logic [CMD_W-1:0] op, logic signed [LABEL_W-1:0] label,
                                          logic [DIST_W-1:0] distance);
        verdict_t v;
        mode_t prior;
        v = '0;
        prior = mode_now;
        case (op)
            CMD_TICK:
            begin
                if (gap_seconds != GAP_MAX)
                begin
                    gap_seconds = gap_seconds + 1'b1;
                end
            end
            CMD_DET_FAIL:
            begin
                if (det_fails != FAIL_MAX)
                begin
                    det_fails = det_fails + 1'b1;
                end
                if (det_fails > settings.det_limit)
                begin
                    mode_now = MODE_ALERT;
                end
            end
            CMD_DET_OK:
            begin
                det_fails = '0;
                if (gap_seconds > settings.interval)
                begin
                    mode_now = MODE_ALERT;
                end
            end
            CMD_RECOG_CHECK:
            begin
                v.is_match = (label == OWNER_LABEL) && (distance <= settings.threshold);
            end
            CMD_RECOG_FAIL:
            begin
                if (recog_fails != FAIL_MAX)
                begin
                    recog_fails = recog_fails + 1'b1;
                end
                if (recog_fails > settings.recog_limit && mode_now != MODE_LOCKDOWN)
                begin
                    mode_now = MODE_LOCKDOWN;
                    v.lock_suppressed = settings.prevent;
                    v.lock_pulse = !settings.prevent;
                end
            end
            CMD_RECOG_OK:
            begin
                recog_fails = '0;
                gap_seconds = '0;
                v.unlock_pulse = (mode_now == MODE_LOCKDOWN);
                mode_now = MODE_SECURE;
            end
            CMD_FORCE_LOCK:
            begin
                v.lock_suppressed = settings.prevent;
                v.lock_pulse = !settings.prevent;
                mode_now = MODE_LOCKDOWN;
            end
            default:
            begin
            end
        endcase
        v.mode = mode_now;
        v.need_recognition = (mode_now != MODE_SECURE);
        v.mode_changed = (mode_now != prior);
        return v;
    endfunction

    function automatic string describe(verdict_t v);
        return $sformatf("mode=%0d need=%0b changed=%0b lock=%0b suppressed=%0b unlock=%0b match=%0b",
                         v.mode, v.need_recognition, v.mode_changed, v.lock_pulse,
                         v.lock_suppressed, v.unlock_pulse, v.is_match);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t got;
        verdict_t want;
        if (!rst_n)
        begin
            settings = '{det_limit: DET_LIMIT_RESET, recog_limit: RECOG_LIMIT_RESET,
                         interval: INTERVAL_RESET, threshold: THRESHOLD_RESET, prevent: 1'b0};
            mode_now = MODE_SECURE;
            det_fails = '0;
            recog_fails = '0;
            gap_seconds = '0;
            expected_verdicts.delete();
            errors = 0;
            results_seen = 0;
            pending <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DET_LIMIT: settings.det_limit = cfg_wdata[LIMIT_W-1:0];
                    CFG_RECOG_LIMIT: settings.recog_limit = cfg_wdata[LIMIT_W-1:0];
                    CFG_INTERVAL: settings.interval = cfg_wdata[LIMIT_W-1:0];
                    CFG_THRESHOLD: settings.threshold = cfg_wdata[THRESH_W-1:0];
                    CFG_PREVENT: settings.prevent = cfg_wdata[0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_ch.valid && in_ch.ready)
            begin
                expected_verdicts.push_back(escalate(in_ch.command, in_ch.face_label,
                                                     in_ch.match_distance));
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got.mode = mode_t'(out_ch.mode);
                got.need_recognition = out_ch.need_recognition;
                got.mode_changed = out_ch.mode_changed;
                got.lock_pulse = out_ch.lock_pulse;
                got.lock_suppressed = out_ch.lock_suppressed;
                got.unlock_pulse = out_ch.unlock_pulse;
                got.is_match = out_ch.is_match;
                if (expected_verdicts.size() == 0)
                begin
                    if (errors < 10)
                    begin
                        $display("%0t: result %0d arrived with no word outstanding: %s",
                                 $time, results_seen, describe(got));
                    end
                    errors++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (got !== want)
                    begin
                        if (errors < 10)
                        begin
                            $display("%0t: result %0d expected %s", $time, results_seen,
                                     describe(want));
                            $display("%0t: result %0d got      %s", $time, results_seen,
                                     describe(got));
                        end
                        errors++;
                    end
                end
                results_seen++;
            end
            pending <= expected_verdicts.size();
            fail_count <= errors;
        end
    end

endmodule

@@ verif/presence_lock_escalation_fsm_unit_tb.sv @@
`timescale 1ns / 1ps

module presence_lock_escalation_fsm_unit_tb;
    import plef_pkg::*;

    localparam int FAIL_COUNT_BITS = 16;
    localparam int GAP_BITS = 17;
    localparam int RANDOM_WORDS = 1650;
    localparam int RANDOM_PHASES = 8;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;
    localparam logic [THRESH_W-1:0] THRESH_MAX = '1;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int pending;
    int fail_count;
    int cycle_count;
    int words_sent;
    bit tx_calm;
    bit rx_calm;
    cfg_t settings;

    plef_in_if in_ch();
    plef_out_if out_ch();

    presence_lock_escalation_fsm_unit #(
        .FAIL_COUNT_BITS(FAIL_COUNT_BITS),
        .GAP_BITS(GAP_BITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    plef_escalation_monitor #(
        .FAIL_COUNT_BITS(FAIL_COUNT_BITS),
        .GAP_BITS(GAP_BITS)
    ) u_escalation_monitor (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .pending(pending),
        .fail_count(fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("presence_lock_escalation_fsm_unit regression: fail");
        $finish;
    end

    function automatic int gap_len(bit calm);
        int r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    initial
    begin
        int hold;
        int stall;
        out_ch.ready <= 1'b1;
        forever
        begin
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            out_ch.ready <= 1'b1;
            repeat (hold) @(posedge clk);
            stall = gap_len(rx_calm);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    task automatic send_word(logic [CMD_W-1:0] op, logic [LABEL_W-1:0] label,
                             logic [DIST_W-1:0] distance);
        int idle;
        idle = gap_len(tx_calm);
        if (idle > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.command <= op;
        in_ch.face_label <= label;
        in_ch.match_distance <= distance;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        if (op != CMD_UNUSED)
        begin
            words_sent++;
        end
    endtask

    task automatic send_op(logic [CMD_W-1:0] op);
        send_word(op, LABEL_W'($urandom), DIST_W'($urandom));
    endtask

    task automatic send_check();
        logic [LABEL_W-1:0] label;
        logic [DIST_W-1:0] distance;
        case ($urandom_range(0, 3))
            0, 1: label = OWNER_LABEL;
            2: label = LABEL_W'($urandom);
            default: label = $urandom_range(0, 1) ? OWNER_LABEL + 1'b1 : OWNER_LABEL - 1'b1;
        endcase
        case ($urandom_range(0, 2))
            0: distance = settings.threshold + DIST_W'($urandom_range(0, 2)) - 1'b1;
            1: distance = DIST_W'($urandom);
            default: distance = '0;
        endcase
        send_word(CMD_RECOG_CHECK, label, distance);
    endtask

    // The sender holds back until every word in flight has produced its result.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic put_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value, int width);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom) << width;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= junk | value;
        @(posedge clk);
    endtask

    task automatic apply_settings(cfg_t s);
        put_reg(CFG_DET_LIMIT, CFG_DATA_W'(s.det_limit), LIMIT_W);
        put_reg(CFG_RECOG_LIMIT, CFG_DATA_W'(s.recog_limit), LIMIT_W);
        put_reg(CFG_INTERVAL, CFG_DATA_W'(s.interval), LIMIT_W);
        put_reg(CFG_THRESHOLD, CFG_DATA_W'(s.threshold), THRESH_W);
        put_reg(CFG_PREVENT, CFG_DATA_W'(s.prevent), 1);
        if ($urandom_range(0, 1))
        begin
            put_reg(CFG_INDEX_W'($urandom_range(int'(CFG_PREVENT) + 1, (1 << CFG_INDEX_W) - 1)),
                    '0, 0);
        end
        cfg_we <= 1'b0;
        settings = s;
    endtask

    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return LIMIT_MAX;
            2: return LIMIT_W'($urandom);
            default: return LIMIT_W'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic cfg_t random_settings();
        cfg_t s;
        s.det_limit = pick_limit();
        s.recog_limit = pick_limit();
        s.interval = pick_limit();
        case ($urandom_range(0, 3))
            0: s.threshold = '0;
            1: s.threshold = THRESH_MAX;
            2: s.threshold = THRESH_W'($urandom);
            default: s.threshold = THRESH_W'($urandom_range(0, 40000));
        endcase
        s.prevent = 1'($urandom_range(0, 1));
        return s;
    endfunction

    function automatic int burst_len(logic [LIMIT_W-1:0] lim);
        if (lim < 10)
        begin
            return $urandom_range(1, int'(lim) + 2);
        end
        return $urandom_range(1, 12);
    endfunction

    task automatic random_episode();
        int n;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                n = burst_len(settings.det_limit);
                repeat (n) send_op(CMD_DET_FAIL);
            end
            2:
            begin
                n = burst_len(settings.interval);
                repeat (n) send_op(CMD_TICK);
                send_op(CMD_DET_OK);
            end
            3, 4:
            begin
                n = burst_len(settings.recog_limit);
                repeat (n) send_op(CMD_RECOG_FAIL);
            end
            5: send_check();
            6: send_op(CMD_RECOG_OK);
            7: send_op(CMD_FORCE_LOCK);
            8:
            begin
                repeat ($urandom_range(1, 4))
                    send_op(CMD_W'($urandom_range(0, (1 << CMD_W) - 1)));
            end
            default: send_op(CMD_W'($urandom_range(int'(CMD_TICK), int'(CMD_FORCE_LOCK))));
        endcase
    endtask

    initial
    begin
        cfg_t s;
        int target;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.command <= '0;
        in_ch.face_label <= '0;
        in_ch.match_distance <= '0;
        words_sent = 0;
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        settings = '{det_limit: DET_LIMIT_RESET, recog_limit: RECOG_LIMIT_RESET,
                     interval: INTERVAL_RESET, threshold: THRESHOLD_RESET, prevent: 1'b0};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(CMD_UNUSED);
        send_word(CMD_RECOG_CHECK, OWNER_LABEL, THRESHOLD_RESET);
        send_word(CMD_RECOG_CHECK, OWNER_LABEL, THRESHOLD_RESET + 1'b1);
        send_word(CMD_RECOG_CHECK, 16'h8000, '0);
        send_word(CMD_RECOG_CHECK, 16'h7FFF, '0);
        send_word(CMD_RECOG_CHECK, 16'hFFFF, '0);
        send_word(CMD_RECOG_CHECK, OWNER_LABEL, THRESH_MAX);
        send_op(CMD_TICK);
        send_op(CMD_DET_OK);
        send_op(CMD_DET_FAIL);
        send_op(CMD_FORCE_LOCK);
        send_op(CMD_FORCE_LOCK);
        send_op(CMD_RECOG_FAIL);
        send_op(CMD_UNUSED);
        send_op(CMD_RECOG_OK);
        settle();

        s = '{det_limit: '0, recog_limit: '0, interval: '0, threshold: THRESH_MAX, prevent: 1'b1};
        apply_settings(s);
        send_word(CMD_RECOG_CHECK, OWNER_LABEL, THRESH_MAX);
        send_op(CMD_FORCE_LOCK);
        send_op(CMD_DET_FAIL);
        send_op(CMD_RECOG_FAIL);
        send_op(CMD_RECOG_FAIL);
        send_op(CMD_RECOG_OK);
        send_op(CMD_DET_OK);
        send_op(CMD_TICK);
        send_op(CMD_DET_OK);
        send_op(CMD_RECOG_OK);
        settle();

        s = '{det_limit: LIMIT_MAX, recog_limit: LIMIT_MAX, interval: LIMIT_MAX,
              threshold: '0, prevent: 1'b0};
        apply_settings(s);
        send_op(CMD_DET_FAIL);
        send_op(CMD_RECOG_FAIL);
        send_op(CMD_TICK);
        send_op(CMD_DET_OK);
        send_word(CMD_RECOG_CHECK, OWNER_LABEL, '0);
        send_word(CMD_RECOG_CHECK, OWNER_LABEL, DIST_W'(1));

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            s = random_settings();
            if (phase < 2)
            begin
                s.prevent = 1'(phase);
            end
            apply_settings(s);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            target = words_sent + RANDOM_WORDS / RANDOM_PHASES;
            while (words_sent < target)
            begin
                random_episode();
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("presence_lock_escalation_fsm_unit regression: pass");
        end
        else
        begin
            $display("presence_lock_escalation_fsm_unit regression: fail");
        end
        $finish;
    end

endmodule
